// File: design/ipf_pkg.sv
`default_nettype none
package ipf_pkg;
  localparam int COORD_W = 20;
  localparam int WEIGHT_W = 16;
  localparam int COEF_W = 32;
  localparam int CFG_W = 32;
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] REG_SINGULAR_SCALE = 3'd0;
endpackage
`default_nettype wire

// File: design/ipf_if.sv
`default_nettype none
interface ipf_in_if;
  logic valid;
  logic ready;
  logic signed [ipf_pkg::COORD_W-1:0] point_x;
  logic signed [ipf_pkg::COORD_W-1:0] point_y;
  logic signed [ipf_pkg::COORD_W-1:0] point_z;
  logic [ipf_pkg::WEIGHT_W-1:0] weight;
  logic last_point;
  modport source (output valid, point_x, point_y, point_z, weight, last_point, input ready);
  modport sink (input valid, point_x, point_y, point_z, weight, last_point, output ready);
endinterface

interface ipf_out_if;
  logic valid;
  logic ready;
  logic fit_status;
  logic signed [ipf_pkg::COEF_W-1:0] coef_a;
  logic signed [ipf_pkg::COEF_W-1:0] coef_b;
  logic signed [ipf_pkg::COEF_W-1:0] coef_d;
  modport source (output valid, fit_status, coef_a, coef_b, coef_d, input ready);
  modport sink (input valid, fit_status, coef_a, coef_b, coef_d, output ready);
endinterface
`default_nettype wire

// File: design/incremental_plane_fit_unit.sv
// Incremental weighted plane fit.
// Points enter one beat at a time on point_in (x, y, z, weight, last_point).
// Each point is folded into saturating sums by one shared 37x33 multiplier
// and one saturating adder, nine products in sequence; point_in.ready stays
// low from acceptance until the block is idle again.
// A point flagged last_point is accumulated and then the fit is finished
// with the same multiplier and a radix-2 restoring divider: eight 64-step
// divisions for means and moments, up to two 31-step divisions for A and B,
// and a few product steps. One result beat then appears on fit_out and the
// sums clear. Points that are not last produce no result beat.
// Synchronous reset clears the sums, the scale register and the output.
// The result sits in an output register; while fit_out.ready is low the
// block keeps accepting and accumulating points, and only a finished fit
// waits for the register to drain.
// singular_scale is written over APB at addresses 0-3 (paddr[2] low); the
// user must write it only while idle, which the block does not enforce.
`default_nettype none
module incremental_plane_fit_unit (
  input  wire logic clk,
  input  wire logic rst,
  ipf_in_if.sink    point_in,
  ipf_out_if.source fit_out,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [ipf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [ipf_pkg::CFG_W-1:0] pwdata,
  output logic [ipf_pkg::CFG_W-1:0] prdata,
  output logic pready
);
  localparam logic [4:0] S_IDLE = 5'd0, S_ACC = 5'd1, S_FCHK = 5'd2, S_MSTART = 5'd3,
    S_MDIV = 5'd4, S_MEND = 5'd5, S_CSTART = 5'd6, S_CDIV = 5'd7, S_CEND = 5'd8,
    S_DD1 = 5'd9, S_DD2 = 5'd10, S_DD3 = 5'd11, S_BND = 5'd12, S_NA1 = 5'd13,
    S_NA2 = 5'd14, S_NA3 = 5'd15, S_QSTART = 5'd16, S_QDIV = 5'd17, S_QEND = 5'd18,
    S_NB1 = 5'd19, S_NB2 = 5'd20, S_NB3 = 5'd21, S_D1 = 5'd22, S_D2 = 5'd23,
    S_D3 = 5'd24, S_OUT = 5'd25;

  localparam logic signed [64:0] MAX48 = 65'sh0_0000_7FFF_FFFF_FFFF;
  localparam logic signed [64:0] MIN48 = -65'sh0_0000_8000_0000_0000;
  localparam logic signed [64:0] MAX64 = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] MIN64 = -65'sh0_8000_0000_0000_0000;
  localparam logic [63:0] MEAN_LIM = 64'd1 << 27;
  localparam logic [63:0] MOM_LIM = 64'd1 << 40;
  localparam logic signed [63:0] COV_LIM = 64'sd1 << 30;
  localparam logic signed [63:0] C32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] C32_MIN = -64'sd2147483648;

  logic [4:0] state;
  logic [3:0] st;
  logic [2:0] k;
  logic qsel, fail;

  logic signed [19:0] px, py, pz;
  logic [15:0] pw;
  logic plast;
  logic [31:0] scale;

  logic signed [47:0] sum1 [3];
  logic signed [63:0] sum2 [6];
  logic [23:0] wtot;
  logic [31:0] peak [2];
  logic signed [36:0] wxr, wyr, wzr;

  logic signed [28:0] mean [3];
  logic signed [31:0] cov [5];
  logic signed [63:0] tmp, dd, num;
  logic signed [31:0] ca, cb, cd;

  logic [63:0] rem, dsh, den, quo;
  logic [6:0] dcnt;
  logic dneg;

  logic signed [36:0] mul_a;
  logic signed [32:0] mul_b;
  logic mul_en;
  logic signed [69:0] prod;

  logic ov, o_status;
  logic signed [31:0] o_a, o_b, o_d;

  logic [32:0] psum;
  assign psum = {1'b0, peak[0]} + {1'b0, peak[1]};

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_en = 1'b1;
    case (state)
      S_ACC: begin
        case (st)
          4'd0: begin mul_a = {21'b0, pw}; mul_b = 33'(px); end
          4'd1: begin mul_a = {21'b0, pw}; mul_b = 33'(py); end
          4'd2: begin mul_a = {21'b0, pw}; mul_b = 33'(pz); end
          4'd3: begin mul_a = wxr; mul_b = 33'(px); end
          4'd4: begin mul_a = wyr; mul_b = 33'(py); end
          4'd5: begin mul_a = wzr; mul_b = 33'(pz); end
          4'd6: begin mul_a = wxr; mul_b = 33'(py); end
          4'd7: begin mul_a = wxr; mul_b = 33'(pz); end
          4'd8: begin mul_a = wyr; mul_b = 33'(pz); end
          default: mul_en = 1'b0;
        endcase
      end
      S_CSTART: begin
        case (k)
          3'd0: begin mul_a = 37'(mean[0]); mul_b = 33'(mean[0]); end
          3'd1: begin mul_a = 37'(mean[1]); mul_b = 33'(mean[1]); end
          3'd2: begin mul_a = 37'(mean[0]); mul_b = 33'(mean[1]); end
          3'd3: begin mul_a = 37'(mean[0]); mul_b = 33'(mean[2]); end
          default: begin mul_a = 37'(mean[1]); mul_b = 33'(mean[2]); end
        endcase
      end
      S_DD1: begin mul_a = 37'(cov[0]); mul_b = 33'(cov[1]); end
      S_DD2: begin mul_a = 37'(cov[2]); mul_b = 33'(cov[2]); end
      S_DD3: begin mul_a = {5'b0, scale}; mul_b = {1'b0, psum[31:0]}; end
      S_NA1: begin mul_a = 37'(cov[4]); mul_b = 33'(cov[2]); end
      S_NA2: begin mul_a = 37'(cov[3]); mul_b = 33'(cov[1]); end
      S_NB1: begin mul_a = 37'(cov[3]); mul_b = 33'(cov[2]); end
      S_NB2: begin mul_a = 37'(cov[4]); mul_b = 33'(cov[0]); end
      S_D1: begin mul_a = 37'(ca); mul_b = 33'(mean[0]); end
      S_D2: begin mul_a = 37'(cb); mul_b = 33'(mean[1]); end
      default: mul_en = 1'b0;
    endcase
  end

  // Saturating accumulate.
  logic [1:0] k1;
  logic [2:0] k2;
  logic signed [63:0] acc_sel, p64;
  logic signed [64:0] addsum;
  logic signed [47:0] sat1;
  logic signed [63:0] sat2;
  logic [36:0] wabs;
  logic [31:0] wabs_sat;
  logic [24:0] wsum;

  always_comb begin
    k1 = 2'(st - 4'd1);
    k2 = 3'(st - 4'd4);
    p64 = prod[63:0];
    acc_sel = (st <= 4'd3) ? 64'(sum1[k1]) : sum2[k2];
    addsum = 65'(acc_sel) + 65'(p64);
    if (addsum > MAX48) sat1 = MAX48[47:0];
    else if (addsum < MIN48) sat1 = MIN48[47:0];
    else sat1 = addsum[47:0];
    if (addsum > MAX64) sat2 = MAX64[63:0];
    else if (addsum < MIN64) sat2 = MIN64[63:0];
    else sat2 = addsum[63:0];
    wabs = prod[36] ? 37'(-prod[36:0]) : prod[36:0];
    wabs_sat = (wabs[36:32] != 5'd0) ? 32'hFFFF_FFFF : wabs[31:0];
    wsum = {1'b0, wtot} + {9'b0, pw};
  end

  // Divider step and finishing arithmetic.
  logic [63:0] r2, rnew, qm, qe;
  logic ge;
  logic [47:0] s1mag;
  logic [2:0] cidx;
  logic signed [63:0] e64, sh64, c64, cs64, covv, dd_d, t64, nd64;
  logic [63:0] nmag, dmag, ddmag;
  logic [32:0] bound;
  logic [31:0] q32;

  always_comb begin
    r2 = {rem[62:0], dsh[63]};
    ge = r2 >= den;
    rnew = ge ? r2 - den : r2;
    s1mag = sum1[k[1:0]][47] ? 48'(-sum1[k[1:0]]) : sum1[k[1:0]];
    case (k)
      3'd0: cidx = 3'd0;
      3'd1: cidx = 3'd1;
      3'd2: cidx = 3'd3;
      3'd3: cidx = 3'd4;
      default: cidx = 3'd5;
    endcase
    qm = (quo > MEAN_LIM) ? MEAN_LIM : quo;
    qe = (quo > MOM_LIM) ? MOM_LIM : quo;
    e64 = dneg ? -$signed(qe) : $signed(qe);
    sh64 = 64'(prod >>> 16);
    c64 = e64 - sh64;
    cs64 = c64 >>> 8;
    if (cs64 > COV_LIM) covv = COV_LIM;
    else if (cs64 < -COV_LIM) covv = -COV_LIM;
    else covv = cs64;
    dd_d = tmp - p64;
    ddmag = dd[63] ? 64'(-dd) : dd;
    bound = {1'b0, prod[63:32]} + (psum[32] ? {1'b0, scale} : 33'd0);
    nmag = num[63] ? 64'(-num) : num;
    dmag = ddmag;
    q32 = {1'b0, quo[30:0]};
    t64 = tmp + sh64;
    nd64 = -t64;
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ipf_pkg::REG_SINGULAR_SCALE[2]) ? scale : '0;
  assign point_in.ready = (state == S_IDLE);
  assign fit_out.valid = ov;
  assign fit_out.fit_status = o_status;
  assign fit_out.coef_a = o_a;
  assign fit_out.coef_b = o_b;
  assign fit_out.coef_d = o_d;

  always_ff @(posedge clk) begin
    if (mul_en) prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st <= '0;
      k <= '0;
      qsel <= 1'b0;
      fail <= 1'b0;
      scale <= '0;
      ov <= 1'b0;
      wtot <= '0;
      for (int i = 0; i < 3; i++) sum1[i] <= '0;
      for (int i = 0; i < 6; i++) sum2[i] <= '0;
      peak[0] <= '0;
      peak[1] <= '0;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[2] == ipf_pkg::REG_SINGULAR_SCALE[2]) begin
        scale <= pwdata;
      end
      if (ov && fit_out.ready && state != S_OUT) ov <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (point_in.valid) begin
            px <= point_in.point_x;
            py <= point_in.point_y;
            pz <= point_in.point_z;
            pw <= point_in.weight;
            plast <= point_in.last_point;
            st <= '0;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (st == 4'd0) wtot <= wsum[24] ? 24'hFF_FFFF : wsum[23:0];
          if (st >= 4'd1 && st <= 4'd3) begin
            sum1[k1] <= sat1;
            if (st == 4'd1) begin
              wxr <= prod[36:0];
              if (wabs_sat > peak[0]) peak[0] <= wabs_sat;
            end
            if (st == 4'd2) begin
              wyr <= prod[36:0];
              if (wabs_sat > peak[1]) peak[1] <= wabs_sat;
            end
            if (st == 4'd3) wzr <= prod[36:0];
          end
          if (st >= 4'd4) sum2[k2] <= sat2;
          st <= st + 4'd1;
          if (st == 4'd9) state <= plast ? S_FCHK : S_IDLE;
        end
        S_FCHK: begin
          ca <= '0;
          cb <= '0;
          cd <= '0;
          k <= '0;
          if (wtot == 24'd0) begin
            fail <= 1'b1;
            state <= S_OUT;
          end else begin
            fail <= 1'b0;
            state <= S_MSTART;
          end
        end
        S_MSTART: begin
          rem <= '0;
          dsh <= {8'b0, s1mag, 8'b0};
          den <= {40'b0, wtot};
          quo <= '0;
          dcnt <= 7'd64;
          dneg <= sum1[k[1:0]][47];
          state <= S_MDIV;
        end
        S_MDIV, S_CDIV, S_QDIV: begin
          rem <= rnew;
          dsh <= {dsh[62:0], 1'b0};
          quo <= {quo[62:0], ge};
          dcnt <= dcnt - 7'd1;
          if (dcnt == 7'd1) begin
            if (state == S_MDIV) state <= S_MEND;
            else if (state == S_CDIV) state <= S_CEND;
            else state <= S_QEND;
          end
        end
        S_MEND: begin
          mean[k[1:0]] <= dneg ? -$signed({1'b0, qm[27:0]}) : $signed({1'b0, qm[27:0]});
          if (k == 3'd2) begin
            k <= '0;
            state <= S_CSTART;
          end else begin
            k <= k + 3'd1;
            state <= S_MSTART;
          end
        end
        S_CSTART: begin
          rem <= '0;
          dsh <= sum2[cidx][63] ? 64'(-sum2[cidx]) : sum2[cidx];
          den <= {40'b0, wtot};
          quo <= '0;
          dcnt <= 7'd64;
          dneg <= sum2[cidx][63];
          state <= S_CDIV;
        end
        S_CEND: begin
          cov[k] <= covv[31:0];
          if (k == 3'd4) begin
            state <= S_DD1;
          end else begin
            k <= k + 3'd1;
            state <= S_CSTART;
          end
        end
        S_DD1: state <= S_DD2;
        S_DD2: begin
          tmp <= p64;
          state <= S_DD3;
        end
        S_DD3: begin
          dd <= dd_d;
          state <= S_BND;
        end
        S_BND: begin
          if (ddmag > {31'b0, bound}) begin
            state <= S_NA1;
          end else begin
            fail <= 1'b1;
            state <= S_OUT;
          end
        end
        S_NA1: state <= S_NA2;
        S_NA2: begin
          tmp <= p64;
          state <= S_NA3;
        end
        S_NA3: begin
          num <= dd_d;
          qsel <= 1'b0;
          state <= S_QSTART;
        end
        S_QSTART: begin
          dneg <= num[63] ^ dd[63];
          if ((nmag >> 15) >= dmag) begin
            if (qsel) cb <= (num[63] ^ dd[63]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            else ca <= (num[63] ^ dd[63]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            state <= qsel ? S_D1 : S_NB1;
          end else begin
            rem <= nmag >> 15;
            dsh <= {nmag[14:0], 49'b0};
            den <= dmag;
            quo <= '0;
            dcnt <= 7'd31;
            state <= S_QDIV;
          end
        end
        S_QEND: begin
          if (qsel) cb <= dneg ? -$signed(q32) : $signed(q32);
          else ca <= dneg ? -$signed(q32) : $signed(q32);
          state <= qsel ? S_D1 : S_NB1;
        end
        S_NB1: state <= S_NB2;
        S_NB2: begin
          tmp <= p64;
          state <= S_NB3;
        end
        S_NB3: begin
          num <= dd_d;
          qsel <= 1'b1;
          state <= S_QSTART;
        end
        S_D1: state <= S_D2;
        S_D2: begin
          tmp <= 64'(mean[2]) + sh64;
          state <= S_D3;
        end
        S_D3: begin
          if (nd64 > C32_MAX) cd <= C32_MAX[31:0];
          else if (nd64 < C32_MIN) cd <= C32_MIN[31:0];
          else cd <= nd64[31:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!ov || fit_out.ready) begin
            ov <= 1'b1;
            o_status <= fail;
            o_a <= fail ? 32'sd0 : ca;
            o_b <= fail ? 32'sd0 : cb;
            o_d <= fail ? 32'sd0 : cd;
            wtot <= '0;
            for (int i = 0; i < 3; i++) sum1[i] <= '0;
            for (int i = 0; i < 6; i++) sum2[i] <= '0;
            peak[0] <= '0;
            peak[1] <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    ov && o_status |-> o_a == 32'sd0 && o_b == 32'sd0 && o_d == 32'sd0)
    else $error("failed fit carries nonzero coefficients");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_MDIV || state == S_CDIV || state == S_QDIV) |-> dcnt != 7'd0)
    else $error("divider running with an empty step count");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    point_in.valid && point_in.ready |=> state == S_ACC && st == 4'd0)
    else $error("accepted point did not start accumulation");

endmodule
`default_nettype wire

// File: test/incremental_plane_fit_unit_test.sv
`timescale 1ns / 1ps
`default_nettype none
module incremental_plane_fit_unit_test;

  localparam int RUN_ITEMS = 800;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int LONG_HOLD = 3000;
  localparam int SETTLE = 40;
  localparam logic [ipf_pkg::PADDR_W-1:0] REG_UNMAPPED = 3'd4;
  localparam longint XMAX = 524287;
  localparam longint XMIN = -524288;

  typedef struct packed {
    logic fit_status;
    logic signed [ipf_pkg::COEF_W-1:0] coef_a;
    logic signed [ipf_pkg::COEF_W-1:0] coef_b;
    logic signed [ipf_pkg::COEF_W-1:0] coef_d;
  } plane_t;

  typedef struct {
    longint x;
    longint y;
    longint z;
    longint w;
    bit last;
    bit typed;
    plane_t fit;
  } point_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [ipf_pkg::PADDR_W-1:0] paddr;
  logic [ipf_pkg::CFG_W-1:0] pwdata, prdata;

  ipf_in_if pin ();
  ipf_out_if pout ();

  incremental_plane_fit_unit u_top (
    .clk(clk), .rst(rst), .point_in(pin.sink), .fit_out(pout.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  plane_t fits_pending[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  longint sum_w1[3];
  longint sum_w2[6];
  longint weight_sum;
  longint unsigned peak_xy[2];
  longint unsigned scale_reg;

  function automatic longint sat_sum(longint a, longint b, longint lo, longint hi);
    if (b > 0 && a > hi - b) return hi;
    if (b < 0 && a < lo - b) return lo;
    return a + b;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint q16_quot(longint num, longint den);
    bit neg;
    longint unsigned n, d, q, r;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = n / d;
    r = n % d;
    if (q >= 64'd32768) return neg ? -64'sd2147483648 : 64'sd2147483647;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint cov_of(longint s2, longint w, longint ma, longint mb);
    longint e, c;
    e = clip(s2 / w, -(64'sd1 <<< 40), 64'sd1 <<< 40);
    c = e - ((ma * mb) >>> 16);
    return clip(c >>> 8, -(64'sd1 <<< 30), 64'sd1 <<< 30);
  endfunction

  function automatic void clear_sums();
    for (int i = 0; i < 3; i++) sum_w1[i] = 0;
    for (int i = 0; i < 6; i++) sum_w2[i] = 0;
    weight_sum = 0;
    peak_xy[0] = 0;
    peak_xy[1] = 0;
  endfunction

  function automatic bit fold_point(longint x, longint y, longint z, longint w, bit last,
                                    output plane_t fit);
    longint wx, wy, wz, lim, mx, my, mz, cxx, cyy, cxy, cxz, cyz, dd, a, b, d;
    longint prod[6];
    longint unsigned ax, ay, p, bound, mag;
    wx = w * x;
    wy = w * y;
    wz = w * z;
    sum_w1[0] = sat_sum(sum_w1[0], wx, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    sum_w1[1] = sat_sum(sum_w1[1], wy, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    sum_w1[2] = sat_sum(sum_w1[2], wz, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    prod[0] = wx * x; prod[1] = wy * y; prod[2] = wz * z;
    prod[3] = wx * y; prod[4] = wx * z; prod[5] = wy * z;
    for (int i = 0; i < 6; i++)
      sum_w2[i] = sat_sum(sum_w2[i], prod[i], 64'sh8000000000000000, 64'sh7FFFFFFFFFFFFFFF);
    weight_sum = weight_sum + w;
    if (weight_sum > 64'hFFFFFF) weight_sum = 64'hFFFFFF;
    ax = wx < 0 ? -wx : wx;
    ay = wy < 0 ? -wy : wy;
    if (ax > 64'hFFFFFFFF) ax = 64'hFFFFFFFF;
    if (ay > 64'hFFFFFFFF) ay = 64'hFFFFFFFF;
    if (ax > peak_xy[0]) peak_xy[0] = ax;
    if (ay > peak_xy[1]) peak_xy[1] = ay;
    fit = '0;
    fit.fit_status = 1'b1;
    if (!last) return 1'b0;
    if (weight_sum != 0) begin
      lim = 64'sd1 <<< 27;
      mx = clip(sum_w1[0] * 256 / weight_sum, -lim, lim);
      my = clip(sum_w1[1] * 256 / weight_sum, -lim, lim);
      mz = clip(sum_w1[2] * 256 / weight_sum, -lim, lim);
      cxx = cov_of(sum_w2[0], weight_sum, mx, mx);
      cyy = cov_of(sum_w2[1], weight_sum, my, my);
      cxy = cov_of(sum_w2[3], weight_sum, mx, my);
      cxz = cov_of(sum_w2[4], weight_sum, mx, mz);
      cyz = cov_of(sum_w2[5], weight_sum, my, mz);
      dd = cxx * cyy - cxy * cxy;
      p = peak_xy[0] + peak_xy[1];
      bound = scale_reg * (p >> 32) + ((scale_reg * (p & 64'hFFFFFFFF)) >> 32);
      mag = dd < 0 ? -dd : dd;
      if (mag > bound) begin
        a = q16_quot(cyz * cxy - cxz * cyy, dd);
        b = q16_quot(cxz * cxy - cyz * cxx, dd);
        d = -(mz + ((a * mx) >>> 16) + ((b * my) >>> 16));
        d = clip(d, -64'sd2147483648, 64'sd2147483647);
        fit.fit_status = 1'b0;
        fit.coef_a = a[31:0];
        fit.coef_b = b[31:0];
        fit.coef_d = d[31:0];
      end
    end
    clear_sums();
    return 1'b1;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : sink_side
    int stall_left;
    int hold_left;
    plane_t want;
    stall_left = 0;
    hold_left = 0;
    pout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pout.valid && pout.ready) begin
        if (fits_pending.size() == 0) begin
          report("unexpected beat", pout.coef_a, 32'h0);
        end else begin
          want = fits_pending.pop_front();
          if (pout.fit_status !== want.fit_status)
            report("fit_status", 32'(pout.fit_status), 32'(want.fit_status));
          if (pout.coef_a !== want.coef_a) report("coef_a", pout.coef_a, want.coef_a);
          if (pout.coef_b !== want.coef_b) report("coef_b", pout.coef_b, want.coef_b);
          if (pout.coef_d !== want.coef_d) report("coef_d", pout.coef_d, want.coef_d);
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      pout.ready <= !rst && hold_left == 0 && stall_left == 0;
    end
  end

  task automatic send_point(longint x, longint y, longint z, longint w, bit last,
                            bit typed, plane_t typed_fit);
    plane_t fit;
    pin.valid <= 1'b1;
    pin.point_x <= x[ipf_pkg::COORD_W-1:0];
    pin.point_y <= y[ipf_pkg::COORD_W-1:0];
    pin.point_z <= z[ipf_pkg::COORD_W-1:0];
    pin.weight <= w[ipf_pkg::WEIGHT_W-1:0];
    pin.last_point <= last;
    do @(posedge clk); while (!pin.ready);
    if (fold_point(x, y, z, w, last, fit)) fits_pending.push_back(typed ? typed_fit : fit);
    if (!calm && $urandom_range(0, 4) == 0) begin
      pin.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic apb_write(logic [ipf_pkg::PADDR_W-1:0] addr,
                           logic [ipf_pkg::CFG_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ipf_pkg::REG_SINGULAR_SCALE) scale_reg = data;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    pin.valid <= 1'b0;
    @(posedge clk);
    while (fits_pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic longint coord(int bits);
    longint span;
    span = 64'sd1 <<< bits;
    return longint'($urandom_range(0, span - 1)) - (span >>> 1);
  endfunction

  task automatic random_set(int count);
    plane_t none;
    int kind, bits, n;
    longint x, y, z, w, cx;
    none = '0;
    for (int sent = 0; sent < count; sent += n) begin
      kind = $urandom_range(0, 19);
      bits = $urandom_range(4, 20);
      n = $urandom_range(2, 12);
      cx = coord(bits);
      for (int i = 0; i < n; i++) begin
        x = coord(bits);
        y = coord(bits);
        z = coord(bits);
        w = $urandom_range(0, 3) == 0 ? 256 : $urandom_range(0, 65535);
        if (kind == 0) w = 0;
        if (kind == 1) x = cx;
        if (kind == 2) begin
          x = coord(20); y = coord(20); z = coord(20);
        end
        send_point(x, y, z, w, (kind == 3 && i != n - 1) ? 1'b0 : i == n - 1, 1'b0, none);
      end
    end
  endtask

  point_row_t plan[] = '{
    '{0, 0, 0, 0, 1, 1, '{1'b1, 0, 0, 0}},
    '{XMAX, XMAX, XMAX, 65535, 1, 1, '{1'b1, 0, 0, 0}},
    '{XMIN, XMIN, XMIN, 65535, 1, 1, '{1'b1, 0, 0, 0}},
    '{0, 0, 256, 256, 0, 0, '0},
    '{256, 0, 512, 256, 0, 0, '0},
    '{0, 256, 768, 256, 1, 0, '0},
    '{256, 256, 0, 256, 0, 0, '0},
    '{512, 512, 100, 256, 0, 0, '0},
    '{768, 768, -100, 256, 1, 1, '{1'b1, 0, 0, 0}},
    '{XMAX, XMIN, 0, 65535, 0, 0, '0},
    '{XMIN, XMAX, XMAX, 1, 0, 0, '0},
    '{0, 0, XMIN, 65535, 0, 0, '0},
    '{XMAX, XMAX, XMAX, 128, 1, 0, '0},
    '{XMAX, XMAX, XMAX, 0, 0, 0, '0},
    '{XMIN, XMIN, XMIN, 0, 1, 1, '{1'b1, 0, 0, 0}},
    '{-1, 3, 7, 300, 0, 0, '0},
    '{5, -2, -9, 700, 0, 0, '0},
    '{2, 9, 1, 65535, 1, 0, '0}
  };

  initial begin : source_side
    plane_t none;
    none = '0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pin.valid <= 1'b0;
    pin.point_x <= '0;
    pin.point_y <= '0;
    pin.point_z <= '0;
    pin.weight <= '0;
    pin.last_point <= 1'b0;
    scale_reg = 0;
    clear_sums();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i])
      send_point(plan[i].x, plan[i].y, plan[i].z, plan[i].w, plan[i].last,
                 plan[i].typed, plan[i].fit);
    drain();

    apb_write(REG_UNMAPPED, 32'hFFFFFFFF);
    random_set(150);
    drain();

    apb_write(ipf_pkg::REG_SINGULAR_SCALE, 32'hFFFFFFFF);
    hold_req = 1'b1;
    random_set(150);
    for (int i = 0; i < 300; i++)
      send_point(i[0] ? XMAX : XMIN, i[1] ? XMAX : XMIN, i[2] ? XMIN : XMAX, 65535,
                 i == 299, 1'b0, none);
    drain();

    apb_write(ipf_pkg::REG_SINGULAR_SCALE, $urandom());
    random_set(100);
    drain();

    apb_write(ipf_pkg::REG_SINGULAR_SCALE, $urandom_range(1, 255));
    calm = 1'b1;
    random_set(RUN_ITEMS - 700);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
design/ipf_pkg.sv
design/ipf_if.sv
design/incremental_plane_fit_unit.sv
test/incremental_plane_fit_unit_test.sv
